### rtl/uqp_pkg.sv
`default_nettype none

package uqp_pkg;

   // Byte codes with a special meaning in a query string.
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   // Result kinds.
   localparam logic [1:0] KIND_KEY   = 2'd0;
   localparam logic [1:0] KIND_VALUE = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // Escape phases.
   localparam logic [1:0] HEX_IDLE  = 2'd0;
   localparam logic [1:0] HEX_FIRST = 2'd1;
   localparam logic [1:0] HEX_SECOND = 2'd2;

   // Depth of the result queue in front of the output channel.
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] char_out;
      logic       pair_keep;
      logic       query_done;
      logic       run_last;
   } result_type;

   // Up to two results that one item causes, first result in slot 0.
   typedef struct packed {
      result_type res0;
      result_type res1;
      logic [1:0] count;
   } decode_type;

   // Returns {valid, digit} for an ASCII hex digit.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### rtl/uqp_decode.sv
`default_nettype none

module uqp_decode (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         char_in,
   input  wire logic               is_end,
   output uqp_pkg::decode_type     dec
);
   import uqp_pkg::*;

   logic       in_value_ff, in_value_in;
   logic [1:0] hex_phase_ff, hex_phase_in;
   logic [7:0] hex_acc_ff, hex_acc_in;
   logic       key_seen_ff, key_seen_in;

   logic [4:0] hex;
   logic [7:0] acc_shift;
   logic       esc;
   logic       pre_valid;
   logic [7:0] pre_char;
   logic       norm_valid;
   result_type pre_res;
   result_type norm_res;
   logic [1:0] data_kind;

   // Decode one item against the current mode and escape state.
   always_comb begin
      hex         = hex_nibble(char_in);
      acc_shift   = {hex_acc_ff[3:0], hex[3:0]};
      esc         = (hex_phase_ff != HEX_IDLE);
      data_kind   = in_value_ff ? KIND_VALUE : KIND_KEY;
      in_value_in  = in_value_ff;
      hex_phase_in = hex_phase_ff;
      hex_acc_in   = hex_acc_ff;
      key_seen_in  = key_seen_ff;
      pre_valid   = 1'b0;
      pre_char    = hex_acc_ff;
      norm_valid  = 1'b0;
      norm_res    = '{kind: data_kind, char_out: char_in, pair_keep: 1'b0,
                      query_done: 1'b0, run_last: 1'b1};

      if (is_end) begin
         // A pending escape is flushed, then the final pair end closes the query.
         pre_valid  = esc;
         norm_valid = 1'b1;
         norm_res   = '{kind: KIND_END, char_out: 8'd0,
                        pair_keep: key_seen_ff | (esc & ~in_value_ff),
                        query_done: 1'b1, run_last: 1'b1};
         in_value_in  = 1'b0;
         hex_phase_in = HEX_IDLE;
         hex_acc_in   = 8'd0;
         key_seen_in  = 1'b0;
      end else if (esc && hex[4]) begin
         // A hex digit inside an escape.
         if (hex_phase_ff == HEX_FIRST) begin
            hex_phase_in = HEX_SECOND;
            hex_acc_in   = acc_shift;
         end else begin
            pre_valid    = 1'b1;
            pre_char     = acc_shift;
            hex_phase_in = HEX_IDLE;
            hex_acc_in   = 8'd0;
            if (!in_value_ff) key_seen_in = 1'b1;
         end
      end else begin
         // An escape cut short by a non-hex byte emits what it gathered.
         if (esc) begin
            pre_valid    = 1'b1;
            hex_phase_in = HEX_IDLE;
            hex_acc_in   = 8'd0;
            if (!in_value_ff) key_seen_in = 1'b1;
         end
         case (char_in)
            CHAR_PLUS: begin
               norm_valid        = 1'b1;
               norm_res.char_out = CHAR_SPACE;
               if (!in_value_ff) key_seen_in = 1'b1;
            end
            CHAR_PERCENT: begin
               hex_phase_in = HEX_FIRST;
               hex_acc_in   = 8'd0;
            end
            CHAR_EQUALS: begin
               in_value_in = 1'b1;
            end
            CHAR_AMP, CHAR_SEMI: begin
               if (in_value_ff) begin
                  norm_valid  = 1'b1;
                  norm_res    = '{kind: KIND_END, char_out: 8'd0,
                                  pair_keep: key_seen_ff | (pre_valid & ~in_value_ff),
                                  query_done: 1'b0, run_last: 1'b1};
                  in_value_in = 1'b0;
                  key_seen_in = 1'b0;
               end
            end
            default: begin
               norm_valid = 1'b1;
               if (!in_value_ff) key_seen_in = 1'b1;
            end
         endcase
      end

      pre_res = '{kind: data_kind, char_out: pre_char, pair_keep: 1'b0,
                  query_done: 1'b0, run_last: ~norm_valid};

      // Pack the results so that the first one always sits in slot 0.
      dec.res0  = pre_valid ? pre_res : norm_res;
      dec.res1  = norm_res;
      dec.count = {1'b0, pre_valid} + {1'b0, norm_valid};
   end

   // Mode and escape state advance on each accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_value_ff  <= 1'b0;
         hex_phase_ff <= HEX_IDLE;
         hex_acc_ff   <= 8'd0;
         key_seen_ff  <= 1'b0;
      end else if (accept) begin
         in_value_ff  <= in_value_in;
         hex_phase_ff <= hex_phase_in;
         hex_acc_ff   <= hex_acc_in;
         key_seen_ff  <= key_seen_in;
      end
   end

endmodule

`default_nettype wire

### rtl/url_query_pair_parser.sv
`default_nettype none

// Streaming decoder for a form-urlencoded query string. Each input item is
// one byte in req_tdata, or an end-of-query marker when req_tlast is high.
// Each item yields zero, one or two result items: decoded key bytes, value
// bytes and pair-end marks (rsp_tuser gives the kind). '+' becomes a space,
// '%' takes up to two hex digits, the first '=' starts the value and '&' or
// ';' in value mode ends a pair. A pair end carries pair_keep (key was not
// empty) and query_done (caused by the end marker); rsp_tlast marks the last
// result of an input item. One input item is taken per clock while the queue
// has room for two results; the output channel delivers one result per clock
// while rsp_tready is high, and a four-entry result queue absorbs items that
// yield two results. Results are registered in the queue and leave in order.
module url_query_pair_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] char_in
   input  wire logic        req_tlast,   // is_end
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] char_out, [8] pair_keep, [9] query_done
   output logic [1:0]       rsp_tuser,   // [1:0] kind
   output logic             rsp_tlast    // run_last
);
   import uqp_pkg::*;

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   result_type           queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]   count_ff, count_in;
   logic                 accept;
   logic                 pop;
   logic [PTR_W-1:0]     wr_next;
   decode_type           dec;
   result_type           head;

   uqp_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .char_in (req_tdata),
      .is_end  (req_tlast),
      .dec     (dec)
   );

   // Room for the two results an item may cause.
   assign req_tready = (count_ff <= COUNT_W'(QUEUE_DEPTH - 2));
   assign accept     = req_tvalid & req_tready;
   assign pop        = rsp_tvalid & rsp_tready;
   assign wr_next    = wr_ptr_ff + PTR_W'(1);

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = accept ? wr_ptr_ff + PTR_W'(dec.count) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (accept ? COUNT_W'(dec.count) : COUNT_W'(0))
                  - (pop ? COUNT_W'(1) : COUNT_W'(0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Result storage; an item writes one or two consecutive entries.
   always_ff @(posedge clock) begin
      if (accept && dec.count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= dec.res0;
      end
      if (accept && dec.count == 2'd2) begin
         queue_ff[wr_next] <= dec.res1;
      end
   end

   // Output channel shows the head of the queue.
   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = {6'd0, head.query_done, head.pair_keep, head.char_out};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.run_last;

endmodule

`default_nettype wire
